>>> rtl/core/per_hart_ready_queue_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Per-hart ready queue scheduler: assertion macros
// Shared concurrent assertion forms used by the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef PER_HART_READY_QUEUE_SCHEDULER_MACROS_SVH
`define PER_HART_READY_QUEUE_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PHRQS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PHRQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/phrqs_pkg.sv
// ----------------------------------------------------------------------------
// Per-hart ready queue scheduler package
// Field widths, operation and register codes, and controller types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package phrqs_pkg;

    // Fixed field widths of the item, result and configuration port.
    localparam int OP_W  = 3;
    localparam int ID_W  = 6;
    localparam int CFG_W = 32;
    localparam int APB_AW = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE  = 3'd3;
    localparam logic [OP_W-1:0] OP_WAKE     = 3'd4;

    // Register index of stop_after_ticks (word address bit).
    localparam logic REG_STOP_AFTER_TICKS = 1'b0;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
    } t_cmd;

endpackage

>>> rtl/core/phrqs_in_if.sv
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying one scheduling request item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface phrqs_in_if;
    import phrqs_pkg::*;

    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic            hart;
    logic [ID_W-1:0] thread_id;
    logic            current_finished;

    modport source (
        output valid, operation, hart, thread_id, current_finished,
        input  ready
    );

    modport sink (
        input  valid, operation, hart, thread_id, current_finished,
        output ready
    );
endinterface

>>> rtl/core/phrqs_out_if.sv
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying one scheduling result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface phrqs_out_if;
    import phrqs_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] thread_out;
    logic            thread_valid;
    logic            assigned_hart;
    logic            requeued;
    logic            queue_empty;
    logic            stop_now;

    modport source (
        output valid, thread_out, thread_valid, assigned_hart, requeued,
               queue_empty, stop_now,
        input  ready
    );

    modport sink (
        input  valid, thread_out, thread_valid, assigned_hart, requeued,
               queue_empty, stop_now,
        output ready
    );
endinterface

>>> rtl/core/phrqs_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phrqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/phrqs_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Two-state sequencer and result-valid tracking for the scheduler datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phrqs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output phrqs_pkg::t_cmd  o_cmd
);
    import phrqs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   exec;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands. The execute state waits only while the result
    // register still holds an item that has not been taken.
    always_comb begin
        accept      = 1'b0;
        exec        = 1'b0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                accept = i_in_valid;
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                exec = !r_out_valid || i_out_ready;
                if (exec) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.exec   = exec;
endmodule

>>> rtl/core/phrqs_dpath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Ready queues, running slots, link and home tables, stop countdown and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phrqs_dpath #(
    parameter int NUM_HARTS   = 2,
    parameter int MAX_THREADS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  phrqs_pkg::t_cmd               i_cmd,
    // Request payload.
    input  logic [phrqs_pkg::OP_W-1:0]    i_operation,
    input  logic                          i_hart,
    input  logic [phrqs_pkg::ID_W-1:0]    i_thread_id,
    input  logic                          i_current_finished,
    // Configuration port.
    input  logic                          i_cfg_we,
    input  logic [phrqs_pkg::APB_AW-1:0]  i_paddr,
    input  logic [phrqs_pkg::CFG_W-1:0]   i_pwdata,
    output logic [phrqs_pkg::CFG_W-1:0]   o_prdata,
    // Result payload.
    output logic [phrqs_pkg::ID_W-1:0]    o_thread_out,
    output logic                          o_thread_valid,
    output logic                          o_assigned_hart,
    output logic                          o_requeued,
    output logic                          o_queue_empty,
    output logic                          o_stop_now
);
    import phrqs_pkg::*;

    localparam int  HW       = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
    localparam int  IDX_W    = $clog2(MAX_THREADS);
    localparam bit  HART1_OK = (NUM_HARTS > 1);
    localparam logic [HW-1:0] LAST_HART = HW'(NUM_HARTS - 1);

    // Thread id to table index, extended or truncated to the table depth.
    function automatic logic [IDX_W-1:0] to_idx(input logic [ID_W-1:0] id);
        logic [IDX_W+ID_W-1:0] ext;
        begin
            ext = {{IDX_W{1'b0}}, id};
            return ext[IDX_W-1:0];
        end
    endfunction

    // Architectural state.
    logic [NUM_HARTS-1:0][ID_W-1:0] r_head,      n_head;
    logic [NUM_HARTS-1:0][ID_W-1:0] r_tail,      n_tail;
    logic [NUM_HARTS-1:0]           r_nonempty,  n_nonempty;
    logic [NUM_HARTS-1:0]           r_run_valid, n_run_valid;
    logic [NUM_HARTS-1:0][ID_W-1:0] r_run_id,    n_run_id;
    logic [HW-1:0]                  r_home_ptr,  n_home_ptr;
    logic [CFG_W-1:0]               r_ticks,     n_ticks;
    logic                           r_stop,      n_stop;
    logic [CFG_W-1:0]               r_stop_after;

    // Captured item.
    logic [OP_W-1:0] r_op;
    logic            r_hart;
    logic [ID_W-1:0] r_tid;
    logic            r_fin;

    // Result register.
    logic [ID_W-1:0] r_thread_out,    n_thread_out;
    logic            r_thread_valid,  n_thread_valid;
    logic            r_assigned_hart, n_assigned_hart;
    logic            r_requeued,      n_requeued;
    logic            r_queue_empty,   n_queue_empty;

    // Table ports.
    logic             link_we;
    logic [IDX_W-1:0] link_waddr;
    logic [ID_W-1:0]  link_wdata;
    logic [IDX_W-1:0] link_raddr;
    logic [ID_W-1:0]  link_rd;
    logic             home_we;
    logic [IDX_W-1:0] home_waddr;
    logic [HW-1:0]    home_wdata;
    logic [IDX_W-1:0] home_raddr;
    logic [HW-1:0]    home_rd;

    // Decoded item fields.
    logic          in_hart_ok;
    logic [HW-1:0] in_hsel;
    logic          hart_ok;
    logic          tid_ok;
    logic [HW-1:0] hsel;
    logic          push_en;
    logic [HW-1:0] push_home;
    logic [ID_W-1:0] push_id;

    // Next-link table: successor of each queued thread.
    phrqs_ram #(.WIDTH(ID_W), .DEPTH(MAX_THREADS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (link_raddr),
        .o_rdata (link_rd)
    );

    // Home hart table, written when a thread is added.
    phrqs_ram #(.WIDTH(HW), .DEPTH(MAX_THREADS)) u_home_ram (
        .i_clk   (i_clk),
        .i_we    (home_we),
        .i_waddr (home_waddr),
        .i_wdata (home_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (home_raddr),
        .o_rdata (home_rd)
    );

    // Table reads issued with the accepted item; state is stable until the
    // update cycle, so the head and running thread seen here stay valid.
    assign in_hart_ok = HART1_OK || !i_hart;
    assign in_hsel    = in_hart_ok ? HW'(i_hart) : '0;
    assign link_raddr = to_idx(r_head[in_hsel]);
    assign home_raddr = (i_operation == OP_TICK) ? to_idx(r_run_id[in_hsel])
                                                 : to_idx(i_thread_id);

    assign hart_ok = HART1_OK || !r_hart;
    assign tid_ok  = ({{(32-ID_W){1'b0}}, r_tid} < 32'(MAX_THREADS));
    assign hsel    = hart_ok ? HW'(r_hart) : '0;

    // Update of queues, running slots and countdown for the captured item.
    always_comb begin
        n_head          = r_head;
        n_tail          = r_tail;
        n_nonempty      = r_nonempty;
        n_run_valid     = r_run_valid;
        n_run_id        = r_run_id;
        n_home_ptr      = r_home_ptr;
        n_ticks         = r_ticks;
        n_stop          = r_stop;
        n_thread_out    = '0;
        n_thread_valid  = 1'b0;
        n_assigned_hart = 1'b0;
        n_requeued      = 1'b0;
        n_queue_empty   = 1'b0;
        link_we         = 1'b0;
        link_waddr      = '0;
        link_wdata      = r_tid;
        home_we         = 1'b0;
        home_waddr      = to_idx(r_tid);
        home_wdata      = r_home_ptr;
        push_en         = 1'b0;
        push_home       = r_home_ptr;
        push_id         = r_tid;

        unique case (r_op)
            OP_ADD: begin
                if (tid_ok) begin
                    home_we         = i_cmd.exec;
                    n_home_ptr      = (r_home_ptr == LAST_HART) ? '0
                                                                : r_home_ptr + HW'(1);
                    push_en         = 1'b1;
                    n_thread_out    = r_tid;
                    n_thread_valid  = 1'b1;
                    n_assigned_hart = r_home_ptr[0];
                    n_requeued      = 1'b1;
                end
            end
            OP_DISPATCH: begin
                if (hart_ok && !r_stop) begin
                    if (r_run_valid[hsel]) begin
                        n_thread_out   = r_run_id[hsel];
                        n_thread_valid = 1'b1;
                    end else if (!r_nonempty[hsel]) begin
                        n_queue_empty = 1'b1;
                    end else begin
                        // Pop the head into the running slot.
                        n_thread_out      = r_head[hsel];
                        n_thread_valid    = 1'b1;
                        n_run_valid[hsel] = 1'b1;
                        n_run_id[hsel]    = r_head[hsel];
                        if (r_head[hsel] == r_tail[hsel]) begin
                            n_nonempty[hsel] = 1'b0;
                        end else begin
                            n_head[hsel] = link_rd;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (hart_ok) begin
                    // Stop countdown runs on hart 0 only.
                    if (!r_hart && (r_ticks != '0)) begin
                        n_ticks = r_ticks - CFG_W'(1);
                        if (r_ticks == CFG_W'(1)) begin
                            n_stop = 1'b1;
                        end
                    end
                    if (r_run_valid[hsel]) begin
                        n_run_valid[hsel] = 1'b0;
                        n_run_id[hsel]    = '0;
                        n_thread_out      = r_run_id[hsel];
                        n_thread_valid    = 1'b1;
                        if (!r_fin) begin
                            push_en         = 1'b1;
                            push_home       = home_rd;
                            push_id         = r_run_id[hsel];
                            n_assigned_hart = home_rd[0];
                            n_requeued      = 1'b1;
                        end
                    end
                end
            end
            OP_RELEASE: begin
                if (hart_ok) begin
                    if (r_run_valid[hsel]) begin
                        n_thread_out   = r_run_id[hsel];
                        n_thread_valid = 1'b1;
                    end
                    n_run_valid[hsel] = 1'b0;
                    n_run_id[hsel]    = '0;
                end
            end
            OP_WAKE: begin
                if (tid_ok) begin
                    push_en         = 1'b1;
                    push_home       = home_rd;
                    n_thread_out    = r_tid;
                    n_thread_valid  = 1'b1;
                    n_assigned_hart = home_rd[0];
                    n_requeued      = 1'b1;
                end
            end
            default: begin
                // Unknown operation: nothing changes.
            end
        endcase

        // Enqueue at the tail of the home queue, linking from the old tail.
        if (push_en) begin
            if (r_nonempty[push_home]) begin
                link_we           = i_cmd.exec;
                link_waddr        = to_idx(r_tail[push_home]);
                link_wdata        = push_id;
                n_tail[push_home] = push_id;
            end else begin
                n_head[push_home]     = push_id;
                n_tail[push_home]     = push_id;
                n_nonempty[push_home] = 1'b1;
            end
        end
    end

    // Control state; a configuration write reloads the countdown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_nonempty   <= '0;
            r_run_valid  <= '0;
            r_run_id     <= '0;
            r_home_ptr   <= '0;
            r_ticks      <= '0;
            r_stop       <= 1'b0;
            r_stop_after <= '0;
        end else if (i_cfg_we) begin
            r_stop_after <= i_pwdata;
            r_ticks      <= i_pwdata;
            r_stop       <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_nonempty  <= n_nonempty;
            r_run_valid <= n_run_valid;
            r_run_id    <= n_run_id;
            r_home_ptr  <= n_home_ptr;
            r_ticks     <= n_ticks;
            r_stop      <= n_stop;
        end
    end

    // Item capture and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_operation;
            r_hart <= i_hart;
            r_tid  <= i_thread_id;
            r_fin  <= i_current_finished;
        end
        if (i_cmd.exec) begin
            r_thread_out    <= n_thread_out;
            r_thread_valid  <= n_thread_valid;
            r_assigned_hart <= n_assigned_hart;
            r_requeued      <= n_requeued;
            r_queue_empty   <= n_queue_empty;
        end
    end

    // Register readback.
    assign o_prdata = (i_paddr[2] == REG_STOP_AFTER_TICKS) ? r_stop_after : '0;

    assign o_thread_out    = r_thread_out;
    assign o_thread_valid  = r_thread_valid;
    assign o_assigned_hart = r_assigned_hart;
    assign o_requeued      = r_requeued;
    assign o_queue_empty   = r_queue_empty;
    assign o_stop_now      = r_stop;
endmodule

>>> rtl/core/per_hart_ready_queue_scheduler.sv
// Each request item is handled in two steps: in the first the next-link and
// home-hart tables are read from their RAMs, in the second the ready queues,
// running slots and stop countdown are updated and the result register is
// loaded. A new item is taken in the cycle after that, also while the
// previous result still waits to be taken; the second step is held only
// while the result register is still full, so no new item is taken until
// the last is through, a pace set by the registered read of the link table.
// ----------------------------------------------------------------------------
// Per-hart ready queue scheduler
// Round-robin home assignment, per-hart FIFO ready queues, dispatch,
// preemption on tick, release, wake, and a stop countdown on hart 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_hart_ready_queue_scheduler #(
    parameter int NUM_HARTS   = 2,
    parameter int MAX_THREADS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    phrqs_in_if.sink                      i_item,
    phrqs_out_if.source                   o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phrqs_pkg::APB_AW-1:0]  paddr,
    input  logic [phrqs_pkg::CFG_W-1:0]   pwdata,
    output logic [phrqs_pkg::CFG_W-1:0]   prdata,
    output logic                          pready
);
    import phrqs_pkg::*;

    t_cmd cmd;
    logic cfg_we;

    // Writes complete in the access cycle; the port never waits.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[2] == REG_STOP_AFTER_TICKS);

    // Sequencer.
    phrqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    // Queue state and result register.
    phrqs_dpath #(
        .NUM_HARTS   (NUM_HARTS),
        .MAX_THREADS (MAX_THREADS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_operation        (i_item.operation),
        .i_hart             (i_item.hart),
        .i_thread_id        (i_item.thread_id),
        .i_current_finished (i_item.current_finished),
        .i_cfg_we           (cfg_we),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .o_prdata           (prdata),
        .o_thread_out       (o_result.thread_out),
        .o_thread_valid     (o_result.thread_valid),
        .o_assigned_hart    (o_result.assigned_hart),
        .o_requeued         (o_result.requeued),
        .o_queue_empty      (o_result.queue_empty),
        .o_stop_now         (o_result.stop_now)
    );
endmodule

>>> rtl/core/phrqs_chk.sv
// ----------------------------------------------------------------------------
// Scheduler port checker
// Checks sequencing and result consistency seen at the scheduler ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "per_hart_ready_queue_scheduler_macros.svh"

module phrqs_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic [phrqs_pkg::ID_W-1:0]   i_thread_out,
    input logic                         i_thread_valid,
    input logic                         i_assigned_hart,
    input logic                         i_requeued,
    input logic                         i_queue_empty
);
    // The block works on one item at a time: busy right after an accept.
    `PHRQS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "item accepted while previous item still in work")

    // A result without a thread reports thread zero.
    `PHRQS_ASSERT_SAME(a_no_thread_zero, i_clk, i_rst_n, i_out_valid && !i_thread_valid, i_thread_out == '0, "thread_out nonzero without thread_valid")

    // A requeue always names the thread; no requeue reports hart zero.
    `PHRQS_ASSERT_SAME(a_requeue_names_thread, i_clk, i_rst_n, i_out_valid && i_requeued, i_thread_valid, "requeued without thread_valid")
    `PHRQS_ASSERT_SAME(a_home_only_on_requeue, i_clk, i_rst_n, i_out_valid && !i_requeued, !i_assigned_hart, "assigned_hart set without requeue")

    // An empty-queue answer carries no thread and no requeue.
    `PHRQS_ASSERT_SAME(a_empty_is_bare, i_clk, i_rst_n, i_out_valid && i_queue_empty, !i_thread_valid && !i_requeued, "queue_empty with thread or requeue")
endmodule

bind per_hart_ready_queue_scheduler phrqs_chk u_phrqs_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_out_valid     (o_result.valid),
    .i_thread_out    (o_result.thread_out),
    .i_thread_valid  (o_result.thread_valid),
    .i_assigned_hart (o_result.assigned_hart),
    .i_requeued      (o_result.requeued),
    .i_queue_empty   (o_result.queue_empty)
);
